// ----- hdl/cidr_rule_rate_threshold_macros.svh -----
// Assertion macros shared by the rule table block; they expect clk_i and rst_ni in scope.
`ifndef CIDR_RULE_RATE_THRESHOLD_MACROS_SVH
`define CIDR_RULE_RATE_THRESHOLD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/crrt_pkg.sv -----
// Types and constants of the CIDR rule rate threshold block.
package crrt_pkg;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned PROTO_W    = 8;
  localparam int unsigned PLEN_W     = 6;
  localparam int unsigned SLOT_OUT_W = 4;

  localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [PLEN_W-1:0] MAX_PLEN = 6'd32;

  // Command queue between the front and the back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   src_addr;
    logic [ADDR_W-1:0]   dst_addr;
    logic [PROTO_W-1:0]  protocol;
    logic [RATE_W-1:0]   pps;
    logic [RATE_W-1:0]   mbps;
    logic [ADDR_W-1:0]   rule_addr;
    logic [PLEN_W-1:0]   rule_prefix_len;
    logic [RATE_W-1:0]   pps_limit;
    logic [RATE_W-1:0]   mbps_limit;
  } in_t;

  typedef struct packed {
    logic                  matched;
    logic                  trigger;
    logic [SLOT_OUT_W-1:0] matched_slot;
    logic                  status;
  } out_t;

  typedef enum logic [1:0] {
    OP_CHECK,
    OP_APPEND,
    OP_CLEAR,
    OP_NOP
  } crrt_op_e;

  // A check carries source, destination and measured rates in addr_a, addr_b,
  // rate_a and rate_b. An append carries the rule address in addr_a and its
  // limits in rate_a and rate_b.
  typedef struct packed {
    crrt_op_e           op;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;
    logic [ADDR_W-1:0]  mask;
    logic [PROTO_W-1:0] protocol;
    logic [RATE_W-1:0]  rate_a;
    logic [RATE_W-1:0]  rate_b;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  mask;
    logic [PROTO_W-1:0] protocol;
    logic [RATE_W-1:0]  pps_limit;
    logic [RATE_W-1:0]  mbps_limit;
  } rule_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } qstat_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } crrt_state_e;

endpackage

// ----- hdl/crrt_front.sv -----
// Front end: accepts input beats, decodes the action and builds queue commands.
module crrt_front (
  input  logic           in_valid_i,
  input  crrt_pkg::in_t  in_data_i,
  input  logic           q_full_i,
  output logic           in_stall_o,
  output logic           push_o,
  output crrt_pkg::cmd_t cmd_o
);
  import crrt_pkg::*;

  logic [PLEN_W-1:0] plen_c;
  logic [PLEN_W-1:0] shamt;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign plen_c = (in_data_i.rule_prefix_len > MAX_PLEN) ? MAX_PLEN : in_data_i.rule_prefix_len;
  assign shamt  = MAX_PLEN - plen_c;

  always_comb begin
    cmd_o          = '0;
    cmd_o.protocol = in_data_i.protocol;
    unique case (in_data_i.action)
      ACT_CHECK: begin
        cmd_o.op     = OP_CHECK;
        cmd_o.addr_a = in_data_i.src_addr;
        cmd_o.addr_b = in_data_i.dst_addr;
        cmd_o.rate_a = in_data_i.pps;
        cmd_o.rate_b = in_data_i.mbps;
      end
      ACT_APPEND: begin
        cmd_o.op     = OP_APPEND;
        cmd_o.addr_a = in_data_i.rule_addr;
        // A zero prefix length gives an empty mask, which covers every address.
        cmd_o.mask   = (plen_c == '0) ? '0 : ({ADDR_W{1'b1}} << shamt);
        cmd_o.rate_a = in_data_i.pps_limit;
        cmd_o.rate_b = in_data_i.mbps_limit;
      end
      ACT_CLEAR: begin
        cmd_o.op = OP_CLEAR;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

// ----- hdl/crrt_queue.sv -----
// Two-entry command queue between the front end and the rule engine.
module crrt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  crrt_pkg::cmd_t   data_i,
  input  logic             pop_i,
  output crrt_pkg::cmd_t   data_o,
  output crrt_pkg::qstat_t stat_o
);
  import crrt_pkg::*;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QDEPTH);

  cmd_t              slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = slots_q[rd_ptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == FULL_CNT);
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ----- hdl/crrt_back.sv -----
// Rule engine: rule memory, rule count, newest-first scan and result register.
module crrt_back #(
  parameter int unsigned RULE_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  crrt_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output crrt_pkg::out_t out_data_o
);
  import crrt_pkg::*;

  localparam int unsigned SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(RULE_SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RULE_SLOTS);

  rule_t                         mem_q [RULE_SLOTS];
  rule_t                         rd_q;
  rule_t                         wr_rule;
  logic                          wr_en;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              count_m1;
  logic [SLOT_W-1:0]             idx_q, idx_d;
  cmd_t                          cmd_q;
  logic                          cmd_load;
  crrt_state_e                   state_q, state_d;
  logic                          out_valid_q;
  out_t                          out_q;
  out_t                          res;
  logic                          res_push;
  logic                          out_free;
  logic                          hit;
  logic                          over;
  logic                          scan_done;
  logic [SLOT_W+SLOT_OUT_W-1:0]  slot_ext;

  assign out_free = !out_valid_q || !out_stall_i;
  assign count_m1 = count_q - 1'b1;
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, idx_q};

  assign wr_rule.addr       = cmd_i.addr_a;
  assign wr_rule.mask       = cmd_i.mask;
  assign wr_rule.protocol   = cmd_i.protocol;
  assign wr_rule.pps_limit  = cmd_i.rate_a;
  assign wr_rule.mbps_limit = cmd_i.rate_b;

  // rd_q holds the rule at idx_q during the scan.
  assign hit = (rd_q.protocol == cmd_q.protocol) &&
               ((((cmd_q.addr_a ^ rd_q.addr) & rd_q.mask) == '0) ||
                (((cmd_q.addr_b ^ rd_q.addr) & rd_q.mask) == '0));
  assign over = ((rd_q.pps_limit != '0) && (cmd_q.rate_a > rd_q.pps_limit)) ||
                ((rd_q.mbps_limit != '0) && (cmd_q.rate_b > rd_q.mbps_limit));
  assign scan_done = hit || (idx_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == OP_CHECK) && (count_q != '0)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    idx_d     = idx_q;
    count_d   = count_q;
    wr_en     = 1'b0;
    cmd_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_CHECK: begin
              if (count_q == '0) begin
                // Empty table: answer no match at once.
                cmd_pop_o = out_free;
                res_push  = out_free;
              end else begin
                cmd_pop_o = 1'b1;
                cmd_load  = 1'b1;
                idx_d     = count_m1[SLOT_W-1:0];
              end
            end
            OP_APPEND: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                res_push  = 1'b1;
                if (count_q == FULL_CNT) begin
                  res.status = 1'b1;
                end else begin
                  wr_en   = 1'b1;
                  count_d = count_q + 1'b1;
                end
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                res_push  = 1'b1;
                count_d   = '0;
              end
            end
            default: begin
              cmd_pop_o = out_free;
              res_push  = out_free;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (out_free) begin
            res_push = 1'b1;
            if (hit) begin
              res.matched      = 1'b1;
              res.trigger      = over;
              res.matched_slot = slot_ext[SLOT_OUT_W-1:0];
            end
          end
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (res_push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_load) begin
      cmd_q <= cmd_i;
    end
    if (res_push) begin
      out_q <= res;
    end
  end

  // Rule memory: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[SLOT_W-1:0]] <= wr_rule;
    end
    rd_q <= mem_q[idx_d];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/cidr_rule_rate_threshold.sv -----
// IPv4 prefix rule table with per-rule packet-rate and bandwidth thresholds.
// An append, clear or unknown action is answered from the rule engine's idle state; a check scans
// the rules newest first up to the first match or the oldest rule (an empty table answers at once).
// Throughput: the rule engine reads one rule per cycle from its single memory read port while it
// scans, and works on one command at a time; a full result register holds it. A 2-entry queue feeds it.
// Reset: rule count, queue and result register empty; rule memory contents undefined, no sweep.
`include "cidr_rule_rate_threshold_macros.svh"

module cidr_rule_rate_threshold #(
  parameter int unsigned RULE_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  crrt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output crrt_pkg::out_t out_data_o
);
  import crrt_pkg::*;

  cmd_t   front_cmd;
  cmd_t   q_cmd;
  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;

  crrt_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_stat.full),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .cmd_o      (front_cmd)
  );

  crrt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_cmd),
    .pop_i  (q_pop),
    .data_o (q_cmd),
    .stat_o (q_stat)
  );

  crrt_back #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_stat.empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `CRRT_ASSERT_NOW(a_trigger_needs_match, out_valid_o && out_data_o.trigger, out_data_o.matched, "trigger raised without a matching rule")
  `CRRT_ASSERT_NOW(a_slot_zero_on_miss, out_valid_o && !out_data_o.matched, out_data_o.matched_slot == '0, "nonzero slot reported without a match")
  `CRRT_ASSERT_NOW(a_status_excludes_match, out_valid_o && out_data_o.status, !out_data_o.matched && !out_data_o.trigger, "append refusal carries check results")
  `CRRT_ASSERT_NEXT(a_queue_fill, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue fill count did not follow a push")

endmodule

// ----- tb/cidr_rule_rate_threshold_checker.sv -----
// Rule table predictor and result checker that watches both channels of the block.
module crrt_verdict_monitor
  import crrt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_beat_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_beat_i,
  output int   mismatches_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SLOTS = 16;

  logic [ADDR_W-1:0]  tbl_addr   [TABLE_SLOTS];
  logic [PLEN_W-1:0]  tbl_plen   [TABLE_SLOTS];
  logic [PROTO_W-1:0] tbl_proto  [TABLE_SLOTS];
  logic [RATE_W-1:0]  tbl_pps    [TABLE_SLOTS];
  logic [RATE_W-1:0]  tbl_mbps   [TABLE_SLOTS];
  logic [4:0]         rules_held = '0;

  out_t pending_verdicts[$];
  int   mismatch_cnt = 0;

  function automatic bit prefix_hits(int unsigned s, logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] m;
    m = (tbl_plen[s] == '0) ? '0 : ({ADDR_W{1'b1}} << (32 - int'(tbl_plen[s])));
    return ((a ^ tbl_addr[s]) & m) == '0;
  endfunction

  // Applies one beat to the shadow table and returns the verdict it must produce.
  function automatic out_t predict_rule_verdict(in_t b);
    out_t v;
    v = '0;
    case (b.action)
      ACT_CHECK: begin
        for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
          if (!v.matched && s < int'(rules_held) && tbl_proto[s] == b.protocol &&
              (prefix_hits(s, b.src_addr) || prefix_hits(s, b.dst_addr))) begin
            v.matched      = 1'b1;
            v.matched_slot = s[SLOT_OUT_W-1:0];
            if (tbl_pps[s] != '0 && b.pps > tbl_pps[s]) v.trigger = 1'b1;
            if (tbl_mbps[s] != '0 && b.mbps > tbl_mbps[s]) v.trigger = 1'b1;
          end
        end
      end
      ACT_APPEND: begin
        if (rules_held >= TABLE_SLOTS) begin
          v.status = 1'b1;
        end else begin
          tbl_addr[rules_held]  = b.rule_addr;
          tbl_plen[rules_held]  = (b.rule_prefix_len > MAX_PLEN) ? MAX_PLEN : b.rule_prefix_len;
          tbl_proto[rules_held] = b.protocol;
          tbl_pps[rules_held]   = b.pps_limit;
          tbl_mbps[rules_held]  = b.mbps_limit;
          rules_held            = rules_held + 1'b1;
        end
      end
      ACT_CLEAR: begin
        rules_held = '0;
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    mismatch_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      rules_held = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with nothing expected, actual %p", $time, out_beat_i);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_beat_i.matched !== want.matched)
            report_field("matched", 32'(want.matched), 32'(out_beat_i.matched));
          if (out_beat_i.trigger !== want.trigger)
            report_field("trigger", 32'(want.trigger), 32'(out_beat_i.trigger));
          if (out_beat_i.matched_slot !== want.matched_slot)
            report_field("matched_slot", 32'(want.matched_slot),
                         32'(out_beat_i.matched_slot));
          if (out_beat_i.status !== want.status)
            report_field("status", 32'(want.status), 32'(out_beat_i.status));
        end
      end
      if (in_valid_i && !in_stall_i) pending_verdicts.push_back(predict_rule_verdict(in_beat_i));
    end
    mismatches_o  <= mismatch_cnt;
    outstanding_o <= pending_verdicts.size();
  end

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
  end

endmodule

// ----- tb/cidr_rule_rate_threshold_tb.sv -----
// Stimulus, handshake pacing and final verdict for the rule table block.
module cidr_rule_rate_threshold_tb;
  import crrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_GOAL   = 550;
  localparam int unsigned HOLD_CYCLES = 80;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_beat   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_beat;
  int   mismatches;
  int   outstanding;

  bit   noisy     = 1'b1;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   sent      = 0;
  int   quiet_cycles = 0;

  logic [ADDR_W-1:0]  addr_pool  [6];
  logic [PROTO_W-1:0] proto_pool [4];

  cidr_rule_rate_threshold DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat)
  );

  crrt_verdict_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off whenever the sender asks for one.
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= noisy && ($urandom_range(99) < 19);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL cidr_rule_rate_threshold");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t random_beat();
    in_t             b;
    logic [9*32-1:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
    b = raw[$bits(in_t)-1:0];
    b.action = ACTION_W'($urandom_range(3, 0));
    return b;
  endfunction

  function automatic in_t rule_beat(logic [ADDR_W-1:0] a, logic [PLEN_W-1:0] len,
                                    logic [PROTO_W-1:0] proto, logic [RATE_W-1:0] plim,
                                    logic [RATE_W-1:0] mlim);
    in_t b;
    b = random_beat();
    b.action          = ACT_APPEND;
    b.rule_addr       = a;
    b.rule_prefix_len = len;
    b.protocol        = proto;
    b.pps_limit       = plim;
    b.mbps_limit      = mlim;
    return b;
  endfunction

  function automatic in_t packet_beat(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                      logic [PROTO_W-1:0] proto, logic [RATE_W-1:0] pps,
                                      logic [RATE_W-1:0] mbps);
    in_t b;
    b = random_beat();
    b.action   = ACT_CHECK;
    b.src_addr = src;
    b.dst_addr = dst;
    b.protocol = proto;
    b.pps      = pps;
    b.mbps     = mbps;
    return b;
  endfunction

  function automatic in_t clear_beat();
    in_t b;
    b = random_beat();
    b.action = ACT_CLEAR;
    return b;
  endfunction

  // Flips a random number of low bits, so prefixes of various lengths still cover it.
  function automatic logic [ADDR_W-1:0] near_addr(logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] span;
    span = (33'd1 << $urandom_range(32, 0)) - 1'b1;
    return a ^ ($urandom & span[ADDR_W-1:0]);
  endfunction

  function automatic logic [RATE_W-1:0] pick_limit();
    case ($urandom_range(2, 0))
      0:       return '0;
      1:       return $urandom_range(1000, 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    return $urandom_range(1, 0) ? $urandom_range(1000, 0) : $urandom;
  endfunction

  function automatic logic [PLEN_W-1:0] pick_plen();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 25) return PLEN_W'($urandom_range(63, 33));
    return PLEN_W'($urandom_range(32, 1));
  endfunction

  task automatic send_beat(input in_t b);
    while (noisy && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain_results();
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    in_t         b;
    int          appends_left;
    int          checks_left;
    int unsigned pi;
    bit          held_off;
    bit          paused;

    held_off = 1'b0;
    paused   = 1'b0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    proto_pool = '{8'd6, 8'd17, 8'd1, 8'($urandom)};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, unknown action, prefix extremes, limit edges, full table.
    send_beat(packet_beat('1, '1, '1, '1, '1));
    b = '1;
    b.action = ACT_UNKNOWN;
    send_beat(b);
    b = '0;
    b.action = ACT_UNKNOWN;
    send_beat(b);
    send_beat(rule_beat('0, '0, 8'd6, '0, '0));
    send_beat(packet_beat('1, '0, 8'd6, '1, '1));
    send_beat(rule_beat(32'hC0A8_0000, 6'd16, 8'd6, 32'd100, '0));
    send_beat(packet_beat(32'hC0A8_1234, 32'h0101_0101, 8'd6, 32'd101, '0));
    send_beat(packet_beat(32'h0101_0101, 32'hC0A8_FFFF, 8'd6, 32'd100, '1));
    send_beat(rule_beat(32'h0A00_0001, 6'd63, 8'd17, '0, 32'd50));
    send_beat(packet_beat('0, 32'h0A00_0001, 8'd17, '1, 32'd51));
    send_beat(packet_beat('0, 32'h0A00_0000, 8'd17, '1, '1));
    send_beat(rule_beat('1, 6'd33, '1, '1, '1));
    send_beat(packet_beat('1, '0, '1, '1, '1));
    send_beat(packet_beat(32'hFFFF_FFFE, '0, '1, '1, '1));
    for (int s = 4; s < 16; s++) send_beat(rule_beat(32'hC0A8_0100, 6'd24, 8'd6, 32'd1, '0));
    // The table is full now, so this append must be refused.
    send_beat(rule_beat('0, '0, 8'd6, '0, '0));
    send_beat(packet_beat(32'hC0A8_0155, '0, 8'd6, 32'd2, '0));
    send_beat(clear_beat());
    send_beat(packet_beat('1, '0, 8'd6, '1, '1));

    // Random part: episodes that build a table and probe it, with some noise beats.
    while (sent < ITEM_GOAL) begin
      if ($urandom_range(9) < 7) send_beat(clear_beat());
      appends_left = $urandom_range(20, 1);
      checks_left  = $urandom_range(30, 5);
      while (appends_left > 0 || checks_left > 0) begin
        if ($urandom_range(99) < 5) begin
          send_beat(random_beat());
        end else if (appends_left > 0 && ($urandom_range(9) < 4 || checks_left == 0)) begin
          appends_left--;
          pi = $urandom_range(5);
          send_beat(rule_beat(near_addr(addr_pool[pi]), pick_plen(),
                              proto_pool[$urandom_range(3)], pick_limit(), pick_limit()));
        end else begin
          checks_left--;
          b = packet_beat(near_addr(addr_pool[$urandom_range(5)]),
                          near_addr(addr_pool[$urandom_range(5)]),
                          proto_pool[$urandom_range(3)], pick_rate(), pick_rate());
          if ($urandom_range(9) == 0) b.src_addr = $urandom;
          if ($urandom_range(9) == 0) b.dst_addr = $urandom;
          if ($urandom_range(19) == 0) b.protocol = PROTO_W'($urandom);
          send_beat(b);
        end
      end
      if (!held_off && sent > 150) begin
        held_off = 1'b1;
        hold_reqs++;
      end
      noisy = !(sent > 250 && sent < 350);
      if (!paused && sent > 450) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        drain_results();
      end
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS cidr_rule_rate_threshold");
    end else begin
      $display("FAIL cidr_rule_rate_threshold");
    end
    $finish;
  end

endmodule

// ----- cidr_rule_rate_threshold.f -----
+incdir+hdl
hdl/crrt_pkg.sv
hdl/crrt_front.sv
hdl/crrt_queue.sv
hdl/crrt_back.sv
hdl/cidr_rule_rate_threshold.sv
tb/cidr_rule_rate_threshold_checker.sv
tb/cidr_rule_rate_threshold_tb.sv
